@@ hw/rtl/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, payload structs, outcome codes and register indexes for
// the ray / triangle hit test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

    // field widths
    localparam int COORD_W = 24;
    localparam int DIR_W   = 18;
    localparam int DEPS_W  = 40;
    localparam int TEPS_W  = 8;

    // internal datapath widths, all exact
    localparam int E_W   = COORD_W + 1;         // edge and origin offset
    localparam int P_W   = DIR_W + E_W + 1;     // dir x e2
    localparam int Q_W   = 2 * E_W + 1;         // t x e1
    localparam int DET_W = E_W + P_W + 2;       // det, nu, nv
    localparam int NT_W  = E_W + Q_W + 2;       // nt

    // configuration port
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X       = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y       = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z       = 3'd5;
    localparam logic [IDX_W-1:0] REG_DET_EPSILON = 3'd6;
    localparam logic [IDX_W-1:0] REG_T_EPSILON   = 3'd7;

    // result codes
    typedef enum logic [2:0] {
        OC_HIT      = 3'd0,
        OC_PARALLEL = 3'd1,
        OC_U_OUT    = 3'd2,
        OC_V_OUT    = 3'd3,
        OC_BEHIND   = 3'd4
    } outcome_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } triangle_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] outcome;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rth_split_mul.sv @@
// ----------------------------------------------------------------------------
// rth_split_mul
// Two-stage signed multiplier: the wide operand is cut into an unsigned low
// part and a signed high part, each multiplied in stage one, then joined.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_split_mul #(
    parameter int A_W  = 25,
    parameter int B_W  = 51,
    parameter int LO_W = 26
) (
    input  logic                    clk,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int PL_W = A_W + LO_W + 1;
    localparam int PH_W = A_W + B_W - LO_W;
    localparam int PR_W = A_W + B_W;

    logic signed [PL_W-1:0] lo_prod_reg;
    logic signed [PH_W-1:0] hi_prod_reg;
    logic signed [PR_W-1:0] prod_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        lo_prod_reg <= a * $signed({1'b0, b[LO_W-1:0]});
        hi_prod_reg <= a * $signed(b[B_W-1:LO_W]);
    end

    // join the partials
    always_ff @(posedge clk)
    begin
        prod_reg <= (PR_W'(hi_prod_reg) <<< LO_W) + PR_W'(lo_prod_reg);
    end

    assign p = prod_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rth_front.sv @@
// ----------------------------------------------------------------------------
// rth_front
// Edge and origin offset vectors, then the two cross products
// P = dir x e2 and Q = t x e1, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_vld,
    input  rth_pkg::triangle_t                 triangle,
    input  logic signed [rth_pkg::COORD_W-1:0] org [0:2],
    input  logic signed [rth_pkg::DIR_W-1:0]   dir [0:2],
    output logic                               out_vld,
    output logic signed [rth_pkg::E_W-1:0]     e1 [0:2],
    output logic signed [rth_pkg::E_W-1:0]     e2 [0:2],
    output logic signed [rth_pkg::E_W-1:0]     tv [0:2],
    output logic signed [rth_pkg::P_W-1:0]     p [0:2],
    output logic signed [rth_pkg::Q_W-1:0]     q [0:2]
);

    import rth_pkg::*;

    localparam int PM_W = DIR_W + E_W;
    localparam int QM_W = 2 * E_W;

    logic [2:0] vld_pipe_reg;

    logic signed [COORD_W-1:0] va [0:2];
    logic signed [COORD_W-1:0] vb [0:2];
    logic signed [COORD_W-1:0] vc [0:2];

    logic signed [E_W-1:0] e1_reg [0:2];
    logic signed [E_W-1:0] e2_reg [0:2];
    logic signed [E_W-1:0] t_reg  [0:2];
    logic signed [E_W-1:0] e1_s2_reg [0:2];
    logic signed [E_W-1:0] e2_s2_reg [0:2];
    logic signed [E_W-1:0] t_s2_reg  [0:2];
    logic signed [E_W-1:0] e1_s3_reg [0:2];
    logic signed [E_W-1:0] e2_s3_reg [0:2];
    logic signed [E_W-1:0] t_s3_reg  [0:2];

    logic signed [PM_W-1:0] pa_reg [0:2];
    logic signed [PM_W-1:0] pb_reg [0:2];
    logic signed [QM_W-1:0] qa_reg [0:2];
    logic signed [QM_W-1:0] qb_reg [0:2];
    logic signed [P_W-1:0]  p_reg  [0:2];
    logic signed [Q_W-1:0]  q_reg  [0:2];

    // vertex lanes
    assign va[0] = triangle.a_x;
    assign va[1] = triangle.a_y;
    assign va[2] = triangle.a_z;
    assign vb[0] = triangle.b_x;
    assign vb[1] = triangle.b_y;
    assign vb[2] = triangle.b_z;
    assign vc[0] = triangle.c_x;
    assign vc[1] = triangle.c_y;
    assign vc[2] = triangle.c_z;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[1:0], in_vld};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        // stage 1: edges and origin offset
        always_ff @(posedge clk)
        begin
            e1_reg[i] <= E_W'(vb[i]) - E_W'(va[i]);
            e2_reg[i] <= E_W'(vc[i]) - E_W'(va[i]);
            t_reg[i]  <= E_W'(org[i]) - E_W'(va[i]);
        end

        // stage 2: cross product terms
        always_ff @(posedge clk)
        begin
            pa_reg[i]    <= dir[J] * e2_reg[K];
            pb_reg[i]    <= dir[K] * e2_reg[J];
            qa_reg[i]    <= t_reg[J] * e1_reg[K];
            qb_reg[i]    <= t_reg[K] * e1_reg[J];
            e1_s2_reg[i] <= e1_reg[i];
            e2_s2_reg[i] <= e2_reg[i];
            t_s2_reg[i]  <= t_reg[i];
        end

        // stage 3: cross product differences
        always_ff @(posedge clk)
        begin
            p_reg[i]     <= P_W'(pa_reg[i]) - P_W'(pb_reg[i]);
            q_reg[i]     <= Q_W'(qa_reg[i]) - Q_W'(qb_reg[i]);
            e1_s3_reg[i] <= e1_s2_reg[i];
            e2_s3_reg[i] <= e2_s2_reg[i];
            t_s3_reg[i]  <= t_s2_reg[i];
        end

        assign e1[i] = e1_s3_reg[i];
        assign e2[i] = e2_s3_reg[i];
        assign tv[i] = t_s3_reg[i];
        assign p[i]  = p_reg[i];
        assign q[i]  = q_reg[i];
    end

    assign out_vld = vld_pipe_reg[2];

endmodule

`default_nettype wire

@@ hw/rtl/rth_dots.sv @@
// ----------------------------------------------------------------------------
// rth_dots
// The four dot products det = e1.P, nu = t.P, nv = dir.Q, nt = e2.Q:
// twelve split multipliers (two stages) and a three-term sum stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_dots (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic signed [rth_pkg::E_W-1:0]    e1 [0:2],
    input  logic signed [rth_pkg::E_W-1:0]    e2 [0:2],
    input  logic signed [rth_pkg::E_W-1:0]    tv [0:2],
    input  logic signed [rth_pkg::DIR_W-1:0]  dir [0:2],
    input  logic signed [rth_pkg::P_W-1:0]    p [0:2],
    input  logic signed [rth_pkg::Q_W-1:0]    q [0:2],
    output logic                              out_vld,
    output logic signed [rth_pkg::DET_W-1:0]  det,
    output logic signed [rth_pkg::DET_W-1:0]  nu,
    output logic signed [rth_pkg::DET_W-1:0]  nv,
    output logic signed [rth_pkg::NT_W-1:0]   nt
);

    import rth_pkg::*;

    localparam int P_LO = P_W / 2;
    localparam int Q_LO = (Q_W + 1) / 2;
    localparam int EP_W = E_W + P_W;
    localparam int DQ_W = DIR_W + Q_W;
    localparam int EQ_W = E_W + Q_W;

    logic [2:0] vld_pipe_reg;

    logic signed [EP_W-1:0] det_term [0:2];
    logic signed [EP_W-1:0] nu_term  [0:2];
    logic signed [DQ_W-1:0] nv_term  [0:2];
    logic signed [EQ_W-1:0] nt_term  [0:2];

    logic signed [DET_W-1:0] det_reg;
    logic signed [DET_W-1:0] nu_reg;
    logic signed [DET_W-1:0] nv_reg;
    logic signed [NT_W-1:0]  nt_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[1:0], in_vld};
        end
    end

    // per-component products
    for (genvar i = 0; i < 3; i++)
    begin : g_term
        rth_split_mul #(.A_W(E_W), .B_W(P_W), .LO_W(P_LO)) u_det_mul (
            .clk (clk),
            .a   (e1[i]),
            .b   (p[i]),
            .p   (det_term[i])
        );

        rth_split_mul #(.A_W(E_W), .B_W(P_W), .LO_W(P_LO)) u_nu_mul (
            .clk (clk),
            .a   (tv[i]),
            .b   (p[i]),
            .p   (nu_term[i])
        );

        rth_split_mul #(.A_W(DIR_W), .B_W(Q_W), .LO_W(Q_LO)) u_nv_mul (
            .clk (clk),
            .a   (dir[i]),
            .b   (q[i]),
            .p   (nv_term[i])
        );

        rth_split_mul #(.A_W(E_W), .B_W(Q_W), .LO_W(Q_LO)) u_nt_mul (
            .clk (clk),
            .a   (e2[i]),
            .b   (q[i]),
            .p   (nt_term[i])
        );
    end

    // three-term sums
    always_ff @(posedge clk)
    begin
        det_reg <= DET_W'(det_term[0]) + DET_W'(det_term[1]) + DET_W'(det_term[2]);
        nu_reg  <= DET_W'(nu_term[0]) + DET_W'(nu_term[1]) + DET_W'(nu_term[2]);
        nv_reg  <= DET_W'(nv_term[0]) + DET_W'(nv_term[1]) + DET_W'(nv_term[2]);
        nt_reg  <= NT_W'(nt_term[0]) + NT_W'(nt_term[1]) + NT_W'(nt_term[2]);
    end

    assign out_vld = vld_pipe_reg[2];
    assign det     = det_reg;
    assign nu      = nu_reg;
    assign nv      = nv_reg;
    assign nt      = nt_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rth_classify.sv @@
// ----------------------------------------------------------------------------
// rth_classify
// Sign normalization of det and the numerators, then the parallel, u, v and
// distance tests without division, ending in the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_classify #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_vld,
    input  logic signed [rth_pkg::DET_W-1:0]   det,
    input  logic signed [rth_pkg::DET_W-1:0]   nu,
    input  logic signed [rth_pkg::DET_W-1:0]   nv,
    input  logic signed [rth_pkg::NT_W-1:0]    nt,
    input  logic [rth_pkg::DEPS_W-1:0]         det_epsilon,
    input  logic [rth_pkg::TEPS_W-1:0]         t_epsilon,
    output logic                               done,
    output rth_pkg::result_t                   result
);

    import rth_pkg::*;

    // det carries 2*COORD_FRAC_BITS+16 fraction bits, epsilon carries 32
    localparam int SH      = 2 * COORD_FRAC_BITS - 16;
    localparam int DET_SHL = (SH < 0) ? -SH : 0;
    localparam int EPS_SHL = (SH > 0) ? SH : 0;
    localparam int CMP_W   = DET_W + 17;
    localparam int N_W     = DET_W + 1;
    localparam int NTN_W   = NT_W + 1;
    localparam int DS_W    = DET_W + 1;
    localparam int TE_W    = TEPS_W + 1;
    localparam int TP_W    = TE_W + DS_W;
    localparam int NTS_W   = NTN_W + 16;
    localparam int TC_W    = NTS_W + 1;

    logic [3:0] vld_pipe_reg;

    logic                     neg;
    logic [DET_W-1:0]         det_abs_reg;
    logic signed [N_W-1:0]    nu_reg;
    logic signed [N_W-1:0]    nv_reg;
    logic signed [NTN_W-1:0]  nt_reg;

    logic signed [DS_W-1:0]   det_s;
    logic [CMP_W-1:0]         par_lhs;
    logic [CMP_W-1:0]         par_rhs;
    logic                     parallel;
    logic                     u_out;
    logic                     v_out;
    logic signed [N_W:0]      uv_sum;
    outcome_t                 code_next;

    outcome_t                 code_s2_reg;
    outcome_t                 code_s3_reg;
    logic signed [NTN_W-1:0]  nt_s2_reg;
    logic signed [NTN_W-1:0]  nt_s3_reg;

    logic signed [TP_W-1:0]   teps_prod;
    logic signed [NTS_W-1:0]  nt_shift;
    logic                     behind;
    outcome_t                 code_final;
    result_t                  result_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[2:0], in_vld};
        end
    end

    // stage 1: make det positive, negating the numerators with it
    assign neg = det[DET_W-1];

    always_ff @(posedge clk)
    begin
        det_abs_reg <= neg ? DET_W'(-det) : DET_W'(det);
        nu_reg      <= neg ? -N_W'(nu) : N_W'(nu);
        nv_reg      <= neg ? -N_W'(nv) : N_W'(nv);
        nt_reg      <= neg ? -NTN_W'(nt) : NTN_W'(nt);
    end

    // stage 2: parallel, u and v tests in priority order
    always_comb
    begin
        det_s    = $signed({1'b0, det_abs_reg});
        par_lhs  = CMP_W'(det_abs_reg) << DET_SHL;
        par_rhs  = CMP_W'(det_epsilon) << EPS_SHL;
        parallel = (det_abs_reg == '0) || (par_lhs < par_rhs);
        u_out    = nu_reg[N_W-1] || (nu_reg > det_s);
        uv_sum   = (N_W+1)'(nu_reg) + (N_W+1)'(nv_reg);
        v_out    = nv_reg[N_W-1] || (uv_sum > (N_W+1)'(det_s));
        if (parallel)
        begin
            code_next = OC_PARALLEL;
        end
        else if (u_out)
        begin
            code_next = OC_U_OUT;
        end
        else if (v_out)
        begin
            code_next = OC_V_OUT;
        end
        else
        begin
            code_next = OC_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        code_s2_reg <= code_next;
        nt_s2_reg   <= nt_reg;
    end

    // stages 2 and 3: t_epsilon * det
    rth_split_mul #(.A_W(TE_W), .B_W(DS_W), .LO_W(DS_W / 2)) u_teps_mul (
        .clk (clk),
        .a   ($signed({1'b0, t_epsilon})),
        .b   (det_s),
        .p   (teps_prod)
    );

    // stage 3: wait for the product
    always_ff @(posedge clk)
    begin
        code_s3_reg <= code_s2_reg;
        nt_s3_reg   <= nt_s2_reg;
    end

    // stage 4: distance test, a hit needs nt * 2^16 > t_epsilon * det
    always_comb
    begin
        nt_shift = $signed({nt_s3_reg, 16'b0});
        behind   = !(TC_W'(teps_prod) < TC_W'(nt_shift));
        if ((code_s3_reg == OC_HIT) && behind)
        begin
            code_final = OC_BEHIND;
        end
        else
        begin
            code_final = code_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.hit     <= (code_final == OC_HIT);
        result_reg.outcome <= code_final;
    end

    assign done   = vld_pipe_reg[3];
    assign result = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ray_triangle_hit_test_top.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_hit_test_top
// Moller-Trumbore ray / triangle hit test, non-culling, fixed point.
// One triangle per transaction against a ray held in configuration.
//
//   channel   | signals                                  | transfer
//   ----------+------------------------------------------+----------------------
//   triangle  | start, busy, triangle                    | start && !busy
//   result    | done, result                             | done, one cycle
//   config    | psel, penable, pwrite, paddr, pwdata,    | psel && penable
//             | prdata, pready                           | && pwrite && pready
//
// A transaction is taken every cycle; busy stays low. Each result passes
// through the pipeline stages to done (three stages of edges and cross
// products, three of dot products, four of tests). Reset clears the valid
// bits and loads the register defaults. There is no stall path: the
// result side takes every transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_hit_test_top #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rth_pkg::triangle_t            triangle,
    output logic                          done,
    output rth_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rth_pkg::APB_AW-1:0]    paddr,
    input  logic [rth_pkg::APB_DW-1:0]    pwdata,
    output logic [rth_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import rth_pkg::*;

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    logic signed [DIR_W-1:0]   dir_x_reg;
    logic signed [DIR_W-1:0]   dir_y_reg;
    logic signed [DIR_W-1:0]   dir_z_reg;
    logic [DEPS_W-1:0]         det_epsilon_reg;
    logic [TEPS_W-1:0]         t_epsilon_reg;

    logic                      wr_en;
    logic [IDX_W-1:0]          reg_idx;
    logic                      in_vld;

    logic signed [COORD_W-1:0] org [0:2];
    logic signed [DIR_W-1:0]   dir [0:2];

    logic                      front_vld;
    logic signed [E_W-1:0]     e1 [0:2];
    logic signed [E_W-1:0]     e2 [0:2];
    logic signed [E_W-1:0]     tv [0:2];
    logic signed [P_W-1:0]     p  [0:2];
    logic signed [Q_W-1:0]     q  [0:2];

    logic                      dots_vld;
    logic signed [DET_W-1:0]   det;
    logic signed [DET_W-1:0]   nu;
    logic signed [DET_W-1:0]   nv;
    logic signed [NT_W-1:0]    nt;

    // register file access
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:APB_AW-IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            dir_x_reg       <= '0;
            dir_y_reg       <= '0;
            dir_z_reg       <= DIR_W'(65536);
            det_epsilon_reg <= DEPS_W'(4295);
            t_epsilon_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ORIGIN_X:    origin_x_reg    <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Z:    origin_z_reg    <= pwdata[COORD_W-1:0];
                REG_DIR_X:       dir_x_reg       <= pwdata[DIR_W-1:0];
                REG_DIR_Y:       dir_y_reg       <= pwdata[DIR_W-1:0];
                REG_DIR_Z:       dir_z_reg       <= pwdata[DIR_W-1:0];
                REG_DET_EPSILON: det_epsilon_reg <= pwdata[DEPS_W-1:0];
                REG_T_EPSILON:   t_epsilon_reg   <= pwdata[TEPS_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:    prdata = APB_DW'(unsigned'(origin_x_reg));
            REG_ORIGIN_Y:    prdata = APB_DW'(unsigned'(origin_y_reg));
            REG_ORIGIN_Z:    prdata = APB_DW'(unsigned'(origin_z_reg));
            REG_DIR_X:       prdata = APB_DW'(unsigned'(dir_x_reg));
            REG_DIR_Y:       prdata = APB_DW'(unsigned'(dir_y_reg));
            REG_DIR_Z:       prdata = APB_DW'(unsigned'(dir_z_reg));
            REG_DET_EPSILON: prdata = APB_DW'(det_epsilon_reg);
            REG_T_EPSILON:   prdata = APB_DW'(t_epsilon_reg);
            default:         prdata = '0;
        endcase
    end

    // ray lanes
    assign org[0] = origin_x_reg;
    assign org[1] = origin_y_reg;
    assign org[2] = origin_z_reg;
    assign dir[0] = dir_x_reg;
    assign dir[1] = dir_y_reg;
    assign dir[2] = dir_z_reg;

    // fully pipelined, a transaction every cycle
    assign busy   = 1'b0;
    assign in_vld = start && !busy;

    rth_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld),
        .triangle (triangle),
        .org      (org),
        .dir      (dir),
        .out_vld  (front_vld),
        .e1       (e1),
        .e2       (e2),
        .tv       (tv),
        .p        (p),
        .q        (q)
    );

    rth_dots u_dots (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (front_vld),
        .e1      (e1),
        .e2      (e2),
        .tv      (tv),
        .dir     (dir),
        .p       (p),
        .q       (q),
        .out_vld (dots_vld),
        .det     (det),
        .nu      (nu),
        .nv      (nv),
        .nt      (nt)
    );

    rth_classify #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (dots_vld),
        .det         (det),
        .nu          (nu),
        .nv          (nv),
        .nt          (nt),
        .det_epsilon (det_epsilon_reg),
        .t_epsilon   (t_epsilon_reg),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire
